// ===== hdl/assert_macros.svh =====
// Assertion macros for the checker file of this project.
// Clock and reset names clk_i and rst_ni must exist where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

// ===== hdl/cpfe_pkg.sv =====
// Package for the CRC-15 packet error code frame engine.
// Holds payload types, codes, queue sizing and the byte-wide CRC step.
package cpfe_pkg;

  localparam logic CMD_TX = 1'b0;
  localparam logic CMD_RX = 1'b1;

  typedef enum logic [1:0] {
    BYTE_FRAME  = 2'd0,
    BYTE_PEC_HI = 2'd1,
    BYTE_PEC_LO = 2'd2
  } byte_kind_e;

  localparam int unsigned CrcWidth = 15;
  localparam logic [CrcWidth-1:0] CrcSeed = 15'd16;
  localparam logic [CrcWidth-1:0] CrcPoly = 15'h4599;

  localparam int unsigned OutqDepth = 4;
  localparam int unsigned OutqPtrW  = $clog2(OutqDepth);
  localparam int unsigned OutqCntW  = $clog2(OutqDepth + 1);
  localparam int unsigned MaxResults = 3;

  typedef struct packed {
    logic       cmd;
    logic [7:0] data_byte;
    logic       frame_end;
  } cpfe_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    byte_kind_e byte_kind;
    logic       run_last;
    logic       pec_good;
  } cpfe_out_t;

  // Up to three results produced by one item, in delivery order.
  typedef struct packed {
    logic [1:0]                      num;
    cpfe_out_t [MaxResults-1:0]      ent;
  } cpfe_push_t;

  // One byte through the CRC, MSB first.
  function automatic logic [CrcWidth-1:0] crc15_byte(input logic [CrcWidth-1:0] rem,
                                                     input logic [7:0] b);
    logic [CrcWidth-1:0] r;
    r = rem ^ {b, 7'd0};
    for (int k = 0; k < 8; k++) begin
      if (r[CrcWidth-1]) begin
        r = {r[CrcWidth-2:0], 1'b0} ^ CrcPoly;
      end else begin
        r = {r[CrcWidth-2:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage

// ===== hdl/cpfe_core.sv =====
// Input register, frame state and per-item result generation.
// Depends on cpfe_pkg for payload types and the CRC step.
module cpfe_core import cpfe_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  cpfe_in_t   in_data_i,
  output logic       in_stall_o,
  input  logic       room_i,
  output cpfe_push_t push_o
);

  logic                in_vld_q;
  cpfe_in_t            in_q;
  logic                load;
  logic                consume;
  logic [CrcWidth-1:0] crc_q, crc_d, crc_step;
  logic [7:0]          held0_q, held0_d, held1_q, held1_d;
  logic [1:0]          cnt_q, cnt_d;
  logic [7:0]          crc_in;
  logic [15:0]         pec;
  logic                good;
  cpfe_push_t          push;

  assign consume    = in_vld_q & room_i;
  assign in_stall_o = in_vld_q & ~room_i;
  assign load       = in_valid_i & ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (load || consume) begin
      in_vld_q <= load;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      in_q <= in_data_i;
    end
  end

  // Transmit feeds the new byte; receive feeds the oldest held byte.
  assign crc_in   = (in_q.cmd == CMD_TX) ? in_q.data_byte : held0_q;
  assign crc_step = crc15_byte(crc_q, crc_in);

  always_comb begin
    crc_d   = crc_q;
    held0_d = held0_q;
    held1_d = held1_q;
    cnt_d   = cnt_q;
    push    = '0;
    pec     = '0;
    good    = 1'b0;
    if (in_q.cmd == CMD_TX) begin
      crc_d = crc_step;
      push.ent[0] = '{out_byte: in_q.data_byte, byte_kind: BYTE_FRAME,
                      run_last: 1'b0, pec_good: 1'b0};
      push.num = 2'd1;
      if (in_q.frame_end) begin
        pec = {crc_step, 1'b0};
        push.ent[1] = '{out_byte: pec[15:8], byte_kind: BYTE_PEC_HI,
                        run_last: 1'b0, pec_good: 1'b0};
        push.ent[2] = '{out_byte: pec[7:0], byte_kind: BYTE_PEC_LO,
                        run_last: 1'b1, pec_good: 1'b0};
        push.num = 2'd3;
      end
    end else begin
      if (cnt_q[1]) begin
        crc_d = crc_step;
        push.ent[0] = '{out_byte: held0_q, byte_kind: BYTE_FRAME,
                        run_last: 1'b0, pec_good: 1'b0};
        push.num = 2'd1;
        held0_d = held1_q;
        held1_d = in_q.data_byte;
      end else if (cnt_q[0]) begin
        held1_d = in_q.data_byte;
      end else begin
        held0_d = in_q.data_byte;
      end
      if (cnt_q != 2'd3) begin
        cnt_d = cnt_q + 2'd1;
      end
      if (in_q.frame_end) begin
        pec  = {crc_d, 1'b0};
        good = (cnt_d == 2'd3) && (held0_d == pec[15:8]) && (held1_d == pec[7:0]);
        if (cnt_q[1]) begin
          push.ent[1] = '{out_byte: 8'd0, byte_kind: BYTE_FRAME,
                          run_last: 1'b1, pec_good: good};
          push.num = 2'd2;
        end else begin
          push.ent[0] = '{out_byte: 8'd0, byte_kind: BYTE_FRAME,
                          run_last: 1'b1, pec_good: good};
          push.num = 2'd1;
        end
      end
    end
    // Any frame end returns the frame state to its reset value.
    if (in_q.frame_end) begin
      crc_d   = CrcSeed;
      held0_d = 8'd0;
      held1_d = 8'd0;
      cnt_d   = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q   <= CrcSeed;
      held0_q <= 8'd0;
      held1_q <= 8'd0;
      cnt_q   <= 2'd0;
    end else if (consume) begin
      crc_q   <= crc_d;
      held0_q <= held0_d;
      held1_q <= held1_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    push_o = push;
    if (!consume) begin
      push_o.num = 2'd0;
    end
  end

endmodule

// ===== hdl/cpfe_outq.sv =====
// Result queue: takes up to three results a cycle, delivers one a cycle unless stalled.
// Depends on cpfe_pkg for the result types and queue sizing.
module cpfe_outq import cpfe_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cpfe_push_t push_i,
  output logic       room_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output cpfe_out_t  out_data_o
);

  cpfe_out_t            mem_q [OutqDepth];
  logic [OutqPtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [OutqCntW-1:0]  cnt_q;
  logic                 pop;

  assign out_valid_o = (cnt_q != '0);
  assign pop         = out_valid_o & ~out_stall_i;
  assign out_data_o  = mem_q[rd_ptr_q];

  // Room for a whole item's results after this cycle's transfer out.
  assign room_o = ({1'b0, cnt_q} + (OutqCntW+1)'(MaxResults) <=
                   (OutqCntW+1)'(OutqDepth) + {{OutqCntW{1'b0}}, pop});

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < MaxResults; k++) begin
      if (2'(k) < push_i.num) begin
        mem_q[wr_ptr_q + OutqPtrW'(k)] <= push_i.ent[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + OutqPtrW'(push_i.num);
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + OutqPtrW'(1);
      end
      cnt_q <= cnt_q + OutqCntW'(push_i.num) - OutqCntW'(pop);
    end
  end

endmodule

// ===== hdl/crc15_pec_frame_engine.sv =====
//  channel | direction | handshake                  | payload
//  in      | input     | in_valid_i / in_stall_o    | in_data_i  (cpfe_in_t)
//  out     | output    | out_valid_o / out_stall_i  | out_data_o (cpfe_out_t)
//
// One item is taken per cycle unless the input stalls; a registered item's
// results enter a four-entry queue and leave one per cycle unless stalled.
// The CRC step is one byte-wide table-free update between two registers.
// A transmit frame end yields three results, so a held item stalls the input
// whenever the queue cannot take three more after this cycle's transfer out.
// Reset clears the queue and restores the frame state (seed 16).
module crc15_pec_frame_engine import cpfe_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  cpfe_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output cpfe_out_t out_data_o
);

  cpfe_push_t push;
  logic       room;

  cpfe_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .in_stall_o (in_stall_o),
    .room_i     (room),
    .push_o     (push)
  );

  cpfe_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== hdl/cpfe_checker.sv =====
// Port-level checks for the frame engine, attached by a bind statement.
// Depends on cpfe_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cpfe_checker import cpfe_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input cpfe_out_t out_data_o
);

  logic out_xfer;
  assign out_xfer = out_valid_o & ~out_stall_i;

  // A stalled result stays put.
  `ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o))

  // The PEC low byte always closes a transmit frame.
  `ASSERT_IMP(a_lo_last, out_valid_o && out_data_o.byte_kind == BYTE_PEC_LO,
              out_data_o.run_last)

  // A good PEC is only flagged on the receive final result.
  `ASSERT_IMP(a_good_final, out_valid_o && out_data_o.pec_good,
              out_data_o.run_last && out_data_o.byte_kind == BYTE_FRAME &&
              out_data_o.out_byte == 8'd0)

  // The high PEC byte is followed at once by the low one.
  `ASSERT_NXT(a_hi_then_lo, out_xfer && out_data_o.byte_kind == BYTE_PEC_HI,
              out_valid_o && out_data_o.byte_kind == BYTE_PEC_LO)

endmodule

bind crc15_pec_frame_engine cpfe_checker u_cpfe_checker (.*);
